[hw/rtl/gadsr_pkg.sv]
// Shared segment codes for the grain envelope shape pipeline.
`default_nettype none

package gadsr_pkg;

	typedef logic [2:0] seg_t;

	localparam seg_t SEG_ATT  = 3'd0;
	localparam seg_t SEG_DEC  = 3'd1;
	localparam seg_t SEG_SUS  = 3'd2;
	localparam seg_t SEG_REL  = 3'd3;
	localparam seg_t SEG_ZERO = 3'd4;

endpackage

`default_nettype wire

[hw/rtl/grain_adsr_envelope_shape.sv]
// Grain ADSR envelope shape evaluator, top level.
//
// One input beat carries phase, attack_time, decay_time, sustain_level and
// release_time (unsigned Q1.FRAC_BITS); one output beat carries level, the
// envelope amplitude clamped to 0..1.0. Every input beat yields one output
// beat, in order.
// Both channels use valid/stall: a beat moves on a rising edge where valid
// is high and stall is low.
// The pipeline has FRAC_BITS+2 stages for the three breakpoint dividers,
// which retire one quotient bit per stage, then FRAC_BITS+3 stages for
// segment select, the segment divider, the scaling multiply and the
// output register.
// Throughput is one beat per cycle while level_stall is low. When level_stall is high, the output
// beat holds and upstream stages keep filling empty slots; item_stall rises
// only when every stage holds a beat.
// Reset (arst_n low) empties the pipeline; no output beat is valid after it.
`default_nettype none

module grain_adsr_envelope_shape #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               item_valid,
	output logic                    item_stall,
	input  wire logic [FRAC_BITS:0] phase,
	input  wire logic [FRAC_BITS:0] attack_time,
	input  wire logic [FRAC_BITS:0] decay_time,
	input  wire logic [FRAC_BITS:0] sustain_level,
	input  wire logic [FRAC_BITS:0] release_time,
	output logic                    level_valid,
	input  wire logic               level_stall,
	output logic [FRAC_BITS:0]      level
);

	logic               brk_rdy;
	logic               seg_rdy;
	logic               brk_valid;
	logic [FRAC_BITS:0] brk_ph;
	logic [FRAC_BITS:0] brk_sl;
	logic [FRAC_BITS:0] brk_att;
	logic [FRAC_BITS:0] brk_dec;
	logic [FRAC_BITS:0] brk_sus;

	gadsr_brk #(.F(FRAC_BITS)) u_brk (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (item_valid),
		.in_rdy        (brk_rdy),
		.phase         (phase),
		.attack_time   (attack_time),
		.decay_time    (decay_time),
		.sustain_level (sustain_level),
		.release_time  (release_time),
		.dn_rdy        (seg_rdy),
		.out_valid     (brk_valid),
		.out_ph        (brk_ph),
		.out_sl        (brk_sl),
		.out_att       (brk_att),
		.out_dec       (brk_dec),
		.out_sus       (brk_sus)
	);

	gadsr_seg #(.F(FRAC_BITS)) u_seg (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (brk_valid),
		.in_rdy    (seg_rdy),
		.ph        (brk_ph),
		.sl        (brk_sl),
		.att       (brk_att),
		.dec       (brk_dec),
		.sus       (brk_sus),
		.dn_rdy    (!level_stall),
		.out_valid (level_valid),
		.level     (level)
	);

	assign item_stall = !brk_rdy;

endmodule

`default_nettype wire

[hw/rtl/gadsr_brk.sv]
// Breakpoint stage: total time and three pipelined restoring dividers, one bit per stage.
`default_nettype none

module gadsr_brk #(
	parameter int F = 16
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	output logic              in_rdy,
	input  wire logic [F:0]   phase,
	input  wire logic [F:0]   attack_time,
	input  wire logic [F:0]   decay_time,
	input  wire logic [F:0]   sustain_level,
	input  wire logic [F:0]   release_time,
	input  wire logic         dn_rdy,
	output logic              out_valid,
	output logic [F:0]        out_ph,
	output logic [F:0]        out_sl,
	output logic [F:0]        out_att,
	output logic [F:0]        out_dec,
	output logic [F:0]        out_sus
);

	localparam int W  = F + 1;
	localparam int TW = W + 2;
	localparam int NS = F + 2;
	localparam logic [TW-1:0] HALF = TW'(1) << (F - 1);

	logic [NS-1:0] vld_s;
	logic [NS:0]   en;

	logic [W-1:0]  ph_s  [NS];
	logic [W-1:0]  sl_s  [NS];
	logic [TW-1:0] tot_s [NS];
	logic [TW-1:0] rem_s [NS][3];
	logic [W-1:0]  quo_s [NS][3];

	always_comb begin
		en[NS] = dn_rdy;
		for (int k = NS - 1; k >= 0; k--) begin
			en[k] = !vld_s[k] || en[k+1];
		end
	end

	assign in_rdy = en[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (en[0]) begin
				vld_s[0] <= in_valid;
			end
			for (int k = 1; k < NS; k++) begin
				if (en[k]) begin
					vld_s[k] <= vld_s[k-1];
				end
			end
		end
	end

	// prepare total and numerators
	always_ff @(posedge clk) begin
		if (en[0]) begin
			ph_s[0]     <= phase;
			sl_s[0]     <= sustain_level;
			tot_s[0]    <= TW'(attack_time) + TW'(decay_time) + TW'(release_time) + HALF;
			rem_s[0][0] <= TW'(attack_time);
			rem_s[0][1] <= TW'(attack_time) + TW'(decay_time);
			rem_s[0][2] <= TW'(attack_time) + TW'(decay_time) + HALF;
			quo_s[0][0] <= '0;
			quo_s[0][1] <= '0;
			quo_s[0][2] <= '0;
		end
	end

	for (genvar k = 1; k < NS; k++) begin : g_step
		logic [TW:0]   sh [3];
		logic [2:0]    ge;
		logic [TW-1:0] nr [3];

		always_comb begin
			for (int j = 0; j < 3; j++) begin
				sh[j] = (k == 1) ? {1'b0, rem_s[k-1][j]} : {rem_s[k-1][j], 1'b0};
				ge[j] = sh[j] >= {1'b0, tot_s[k-1]};
				nr[j] = ge[j] ? TW'(sh[j] - {1'b0, tot_s[k-1]}) : TW'(sh[j]);
			end
		end

		always_ff @(posedge clk) begin
			if (en[k]) begin
				ph_s[k]  <= ph_s[k-1];
				sl_s[k]  <= sl_s[k-1];
				tot_s[k] <= tot_s[k-1];
				for (int j = 0; j < 3; j++) begin
					rem_s[k][j] <= nr[j];
					quo_s[k][j] <= {quo_s[k-1][j][W-2:0], ge[j]};
				end
			end
		end
	end

	assign out_valid = vld_s[NS-1];
	assign out_ph    = ph_s[NS-1];
	assign out_sl    = sl_s[NS-1];
	assign out_att   = quo_s[NS-1][0];
	assign out_dec   = quo_s[NS-1][1];
	assign out_sus   = quo_s[NS-1][2];

endmodule

`default_nettype wire

[hw/rtl/gadsr_seg.sv]
// Segment stage: segment select, pipelined segment divider, scale and clamp.
`default_nettype none

module gadsr_seg #(
	parameter int F = 16
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_rdy,
	input  wire logic [F:0] ph,
	input  wire logic [F:0] sl,
	input  wire logic [F:0] att,
	input  wire logic [F:0] dec,
	input  wire logic [F:0] sus,
	input  wire logic       dn_rdy,
	output logic            out_valid,
	output logic [F:0]      level
);

	import gadsr_pkg::*;

	localparam int W  = F + 1;
	localparam int ND = F + 1;
	localparam int NS = F + 3;
	localparam logic [W-1:0] ONE = {1'b1, {F{1'b0}}};

	logic [NS-1:0] vld_s;
	logic [NS:0]   en;

	seg_t         code_s [ND];
	logic [W-1:0] sl_s   [ND];
	logic [W-1:0] rem_s  [ND];
	logic [W-1:0] den_s  [ND];
	logic [F-1:0] quo_s  [ND];

	seg_t           code_sm;
	logic [W-1:0]   sl_sm;
	logic [F-1:0]   quo_sm;
	logic [2*W-1:0] prd_sm;
	logic [W-1:0]   lvl_so;

	always_comb begin
		en[NS] = dn_rdy;
		for (int k = NS - 1; k >= 0; k--) begin
			en[k] = !vld_s[k] || en[k+1];
		end
	end

	assign in_rdy = en[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (en[0]) begin
				vld_s[0] <= in_valid;
			end
			for (int k = 1; k < NS; k++) begin
				if (en[k]) begin
					vld_s[k] <= vld_s[k-1];
				end
			end
		end
	end

	seg_t         p_code;
	logic [W-1:0] p_x;
	logic [W-1:0] p_den;

	// pick segment, numerator and divisor
	always_comb begin
		p_code = SEG_ZERO;
		p_x    = '0;
		p_den  = ONE;
		if (ph < att) begin
			p_code = SEG_ATT;
			p_x    = ph;
			p_den  = att;
		end else if (ph < dec) begin
			p_code = SEG_DEC;
			p_x    = ph - att;
			p_den  = dec - att;
		end else if (ph < sus) begin
			p_code = SEG_SUS;
		end else if (sus < ONE) begin
			p_x   = ph - sus;
			p_den = ONE - sus;
			if (p_x < p_den) begin
				p_code = SEG_REL;
			end else begin
				p_code = SEG_ZERO;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			code_s[0] <= p_code;
			sl_s[0]   <= sl;
			rem_s[0]  <= p_x;
			den_s[0]  <= p_den;
			quo_s[0]  <= '0;
		end
	end

	for (genvar k = 1; k < ND; k++) begin : g_div
		logic [W:0]   sh;
		logic         ge;
		logic [W-1:0] nr;

		always_comb begin
			sh = {rem_s[k-1], 1'b0};
			ge = sh >= {1'b0, den_s[k-1]};
			nr = ge ? W'(sh - {1'b0, den_s[k-1]}) : W'(sh);
		end

		always_ff @(posedge clk) begin
			if (en[k]) begin
				code_s[k] <= code_s[k-1];
				sl_s[k]   <= sl_s[k-1];
				den_s[k]  <= den_s[k-1];
				rem_s[k]  <= nr;
				quo_s[k]  <= {quo_s[k-1][F-2:0], ge};
			end
		end
	end

	logic [W-1:0] sc;
	logic [W-1:0] ma;
	logic [W-1:0] mb;

	always_comb begin
		sc = (sl_s[ND-1] > ONE) ? ONE : sl_s[ND-1];
		if (code_s[ND-1] == SEG_DEC) begin
			ma = ONE - sc;
			mb = {1'b0, quo_s[ND-1]};
		end else begin
			ma = sl_s[ND-1];
			mb = ONE - {1'b0, quo_s[ND-1]};
		end
	end

	always_ff @(posedge clk) begin
		if (en[ND]) begin
			code_sm <= code_s[ND-1];
			sl_sm   <= sl_s[ND-1];
			quo_sm  <= quo_s[ND-1];
			prd_sm  <= ma * mb;
		end
	end

	logic [W:0]   scl;
	logic [W-1:0] lvl;

	always_comb begin
		scl = prd_sm[2*W-1:F];
		unique case (code_sm)
			SEG_ATT: lvl = {1'b0, quo_sm};
			SEG_DEC: lvl = ONE - W'(scl);
			SEG_SUS: lvl = (sl_sm > ONE) ? ONE : sl_sm;
			SEG_REL: lvl = (scl > {1'b0, ONE}) ? ONE : W'(scl);
			default: lvl = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en[NS-1]) begin
			lvl_so <= lvl;
		end
	end

	assign out_valid = vld_s[NS-1];
	assign level     = lvl_so;

endmodule

`default_nettype wire

[hw/rtl/gadsr_chk.sv]
// Port checker for the grain envelope shape evaluator, with its bind.
`default_nettype none

module gadsr_chk #(
	parameter int FRAC_BITS = 16
) (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               level_valid,
	input wire logic               level_stall,
	input wire logic [FRAC_BITS:0] level
);

	localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		level_valid |-> level <= ONE)
		else $error("level above 1.0");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		level_valid && level_stall |=> level_valid && $stable(level))
		else $error("stalled output beat changed");

	a_reset_empty: assert property (@(posedge clk)
		!arst_n |-> !level_valid)
		else $error("output beat valid during reset");

endmodule

bind grain_adsr_envelope_shape gadsr_chk #(.FRAC_BITS(FRAC_BITS)) u_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.level_valid (level_valid),
	.level_stall (level_stall),
	.level       (level)
);

`default_nettype wire

[sim/grain_adsr_envelope_shape_test.sv]
// Self-checking testbench for the grain ADSR envelope shape evaluator.
`default_nettype none

module grain_adsr_envelope_shape_test;

	localparam int FB = 16;
	localparam longint ONE = 64'd1 << FB;
	localparam longint HALF = 64'd1 << (FB - 1);
	localparam int WATCHDOG_LIMIT = 20000;

	logic clk = 1'b0;
	logic arst_n;
	logic item_valid = 1'b0;
	logic item_stall;
	logic [FB:0] phase = '0;
	logic [FB:0] attack_time = '0;
	logic [FB:0] decay_time = '0;
	logic [FB:0] sustain_level = '0;
	logic [FB:0] release_time = '0;
	logic level_valid;
	logic level_stall = 1'b0;
	logic [FB:0] level;

	logic [FB:0] level_queue[$];
	int mismatches = 0;
	int idle_pct = 0;
	int stall_pct = 0;
	int quiet_cycles = 0;

	grain_adsr_envelope_shape #(.FRAC_BITS(FB)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.phase(phase),
		.attack_time(attack_time),
		.decay_time(decay_time),
		.sustain_level(sustain_level),
		.release_time(release_time),
		.level_valid(level_valid),
		.level_stall(level_stall),
		.level(level)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic longint unsigned sat_one(longint unsigned v);
		return v > ONE ? ONE : v;
	endfunction

	function automatic logic [FB:0] envelope_level(logic [FB:0] ph_i, logic [FB:0] a_i,
			logic [FB:0] d_i, logic [FB:0] s_i, logic [FB:0] r_i);
		longint unsigned ph, a, d, s, r, total, att_end, dec_end, sus_end, seg, lvl, sc;
		ph = 64'(ph_i); a = 64'(a_i); d = 64'(d_i); s = 64'(s_i); r = 64'(r_i);
		total = a + d + r + HALF;
		att_end = (a << FB) / total;
		dec_end = ((a + d) << FB) / total;
		sus_end = ((a + d + HALF) << FB) / total;
		if (ph < att_end)
			return (FB+1)'(sat_one((ph << FB) / att_end));
		if (ph < dec_end) begin
			sc = sat_one(s);
			seg = ((ph - att_end) << FB) / (dec_end - att_end);
			lvl = ONE - (((ONE - sc) * seg) >> FB);
			return (FB+1)'(sat_one(lvl));
		end
		if (ph < sus_end)
			return (FB+1)'(sat_one(s));
		if (sus_end >= ONE)
			return '0;
		seg = ((ph - sus_end) << FB) / (ONE - sus_end);
		if (seg >= ONE)
			return '0;
		lvl = (s * (ONE - seg)) >> FB;
		return (FB+1)'(sat_one(lvl));
	endfunction

	// send one beat, idling first at random
	task automatic send_beat(int p, int a, int d, int s, int r);
		logic [FB:0] pv, av, dv, sv, rv;
		pv = (FB+1)'(p);
		av = (FB+1)'(a);
		dv = (FB+1)'(d);
		sv = (FB+1)'(s);
		rv = (FB+1)'(r);
		while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		phase <= pv;
		attack_time <= av;
		decay_time <= dv;
		sustain_level <= sv;
		release_time <= rv;
		level_queue.push_back(envelope_level(pv, av, dv, sv, rv));
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
	endtask

	task automatic wait_drained();
		item_valid <= 1'b0;
		while (level_queue.size() != 0)
			@(posedge clk);
	endtask

	always @(posedge clk) begin
		level_stall <= (stall_pct > 0 && $urandom_range(99) < stall_pct);
		if (arst_n && level_valid && !level_stall) begin
			if (level_queue.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected level beat %0d", level);
			end else begin
				if (level !== level_queue[0]) begin
					mismatches++;
					if (mismatches <= 10)
						$display("level mismatch: expected %0d got %0d",
							level_queue[0], level);
				end
				void'(level_queue.pop_front());
			end
		end
		if ((item_valid && !item_stall) || (level_valid && !level_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("[grain_adsr_envelope_shape] ERROR");
			$finish;
		end
	end

	task automatic test_directed();
		send_beat(0, 0, 0, 0, 0);
		send_beat(65536, 0, 0, 65536, 0);
		send_beat(65535, 0, 0, 65536, 0);
		send_beat(70000, 6554, 6554, 32768, 0);
		send_beat(131071, 131071, 131071, 131071, 131071);
		send_beat(0, 131071, 131071, 131071, 131071);
		send_beat(3000, 13107, 13107, 40000, 13107);
		send_beat(10000, 13107, 13107, 40000, 13107);
		send_beat(30000, 13107, 13107, 40000, 13107);
		send_beat(60000, 13107, 13107, 40000, 13107);
		send_beat(65536, 13107, 13107, 40000, 13107);
		send_beat(5000, 0, 20000, 30000, 20000);
		send_beat(5000, 20000, 0, 30000, 20000);
		send_beat(40000, 20000, 0, 30000, 20000);
		send_beat(60000, 20000, 20000, 100000, 20000);
		send_beat(15000, 20000, 20000, 100000, 20000);
		send_beat(120000, 1000, 1000, 50000, 1000);
		send_beat(65536, 65536, 65536, 0, 65536);
	endtask

	task automatic test_random(int count);
		int p, s;
		for (int i = 0; i < count; i++) begin
			p = ($urandom_range(9) == 0) ? $urandom_range(131071) : $urandom_range(65536);
			s = ($urandom_range(9) == 0) ? $urandom_range(131071) : $urandom_range(65536);
			if ($urandom_range(3) == 0)
				send_beat(p, $urandom_range(131071), $urandom_range(131071), s,
					$urandom_range(131071));
			else
				send_beat(p, $urandom_range(32768), $urandom_range(32768), s,
					$urandom_range(3) == 0 ? 0 : $urandom_range(32768));
		end
	endtask

	task automatic test_idle_phases();
		idle_pct = 0; stall_pct = 0;
		test_random(160);
		idle_pct = 56; stall_pct = 0;
		test_random(160);
		wait_drained();
		idle_pct = 0; stall_pct = 56;
		test_random(160);
		idle_pct = 8; stall_pct = 8;
		test_random(160);
		idle_pct = 0; stall_pct = 0;
	endtask

	initial begin
		arst_n <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		wait_drained();
		test_idle_phases();
		wait_drained();
		repeat (50) @(posedge clk);
		if (mismatches == 0 && level_queue.size() == 0)
			$display("[grain_adsr_envelope_shape] OK");
		else
			$display("[grain_adsr_envelope_shape] ERROR");
		$finish;
	end

endmodule

`default_nettype wire

[filelist.f]
hw/rtl/gadsr_pkg.sv
hw/rtl/gadsr_brk.sv
hw/rtl/gadsr_seg.sv
hw/rtl/grain_adsr_envelope_shape.sv
hw/rtl/gadsr_chk.sv
sim/grain_adsr_envelope_shape_test.sv
